### rtl/smq_pkg.sv
// ----------------------------------------------------------------------------
// smq_pkg: shared definitions for the shared-buffer multi-queue
// Default sizes, field widths, status and operation codes, sequencer states
// and the memory control group.
// ----------------------------------------------------------------------------
package smq_pkg;

	// default sizes
	localparam int SLOTS_DEF  = 64;
	localparam int QUEUES_DEF = 8;

	// fixed field widths
	localparam int DATA_W   = 32;
	localparam int QID_W    = 3;
	localparam int STATUS_W = 2;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// operation codes
	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_LINK,
		S_DEQ
	} state_t;

	// memory port control
	typedef struct packed {
		logic re;
		logic we;
	} mem_ctl_t;

endpackage

### rtl/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue: several FIFO queues in one shared slot store
// Queues are chained through a next-slot link store; unused slots sit on a
// free list. Status reports full on enqueue and empty on dequeue.
// ----------------------------------------------------------------------------
// result: registered out of the lookup state for full, empty and enqueue into
//   an empty queue, out of the link state for enqueue behind a tail and out
//   of the dequeue state for dequeue. flow: one item at a time, taken in idle;
//   a pending result lets one more item in, which then waits
// reset: all queues empty, every slot free; a fill mark stands in for the
//   initial link chain, so no clearing pass is needed
module shared_buffer_multi_queue #(
	parameter int SLOTS  = smq_pkg::SLOTS_DEF,
	parameter int QUEUES = smq_pkg::QUEUES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [smq_pkg::QID_W-1:0]         queue_id,
	input  logic signed [smq_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [smq_pkg::STATUS_W-1:0]      status,
	output logic signed [smq_pkg::DATA_W-1:0] data_out
);

	localparam int PW = $clog2(SLOTS + 1);
	localparam int AW = $clog2(SLOTS);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	smq_pkg::mem_ctl_t qt_ctl, link_ctl, data_ctl;
	logic [QW-1:0] qt_rd_addr, qt_wr_addr;
	logic [PW-1:0] qt_head_wr, qt_tail_wr, qt_head_rd, qt_tail_rd;
	logic [AW-1:0] link_rd_addr, link_wr_addr, data_rd_addr, data_wr_addr;
	logic [PW-1:0] link_wr_data, link_rd_data;
	logic [smq_pkg::DATA_W-1:0] data_wr_data, data_rd_data;

	// sequencer
	smq_seq #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.queue_id     (queue_id),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.data_out     (data_out),
		.qt_ctl       (qt_ctl),
		.qt_rd_addr   (qt_rd_addr),
		.qt_wr_addr   (qt_wr_addr),
		.qt_head_wr   (qt_head_wr),
		.qt_tail_wr   (qt_tail_wr),
		.qt_head_rd   (qt_head_rd),
		.qt_tail_rd   (qt_tail_rd),
		.link_ctl     (link_ctl),
		.link_rd_addr (link_rd_addr),
		.link_wr_addr (link_wr_addr),
		.link_wr_data (link_wr_data),
		.link_rd_data (link_rd_data),
		.data_ctl     (data_ctl),
		.data_rd_addr (data_rd_addr),
		.data_wr_addr (data_wr_addr),
		.data_wr_data (data_wr_data),
		.data_rd_data (data_rd_data)
	);

	// head and tail pointers per queue
	smq_qtab #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_qtab (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (qt_ctl),
		.rd_addr (qt_rd_addr),
		.wr_addr (qt_wr_addr),
		.head_wr (qt_head_wr),
		.tail_wr (qt_tail_wr),
		.head_rd (qt_head_rd),
		.tail_rd (qt_tail_rd)
	);

	// next-slot links
	smq_ram #(.W(PW), .DEPTH(SLOTS)) u_link (
		.clk     (clk),
		.ctl     (link_ctl),
		.rd_addr (link_rd_addr),
		.wr_addr (link_wr_addr),
		.wr_data (link_wr_data),
		.rd_data (link_rd_data)
	);

	// slot data words
	smq_ram #(.W(smq_pkg::DATA_W), .DEPTH(SLOTS)) u_data (
		.clk     (clk),
		.ctl     (data_ctl),
		.rd_addr (data_rd_addr),
		.wr_addr (data_wr_addr),
		.wr_data (data_wr_data),
		.rd_data (data_rd_data)
	);

endmodule

### rtl/smq_ram.sv
// ----------------------------------------------------------------------------
// smq_ram: one write port, one read port memory
// Synchronous write, registered read with read enable.
// ----------------------------------------------------------------------------
module smq_ram #(
	parameter int W     = smq_pkg::DATA_W,
	parameter int DEPTH = smq_pkg::SLOTS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  smq_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  logic [W-1:0]     wr_data,
	output logic [W-1:0]     rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/smq_qtab.sv
// ----------------------------------------------------------------------------
// smq_qtab: per-queue head and tail pointer table
// Memory of head/tail pairs with one valid flag per queue; a queue never
// written reads back as null head and null tail.
// ----------------------------------------------------------------------------
module smq_qtab #(
	parameter int SLOTS  = smq_pkg::SLOTS_DEF,
	parameter int QUEUES = smq_pkg::QUEUES_DEF,
	localparam int PW    = $clog2(SLOTS + 1),
	localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smq_pkg::mem_ctl_t ctl,
	input  logic [QW-1:0]     rd_addr,
	input  logic [QW-1:0]     wr_addr,
	input  logic [PW-1:0]     head_wr,
	input  logic [PW-1:0]     tail_wr,
	output logic [PW-1:0]     head_rd,
	output logic [PW-1:0]     tail_rd
);

	logic [2*PW-1:0] mem [QUEUES];
	logic [QUEUES-1:0] valid_q;
	logic [2*PW-1:0] rd_word_q;
	logic rd_vld_q;

	// valid flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// pointer storage and registered read
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[wr_addr] <= {head_wr, tail_wr};
		end
		if (ctl.re) begin
			rd_word_q <= mem[rd_addr];
			rd_vld_q  <= valid_q[rd_addr];
		end
	end

	// unwritten entries read as null
	assign head_rd = rd_vld_q ? rd_word_q[2*PW-1:PW] : PW'(SLOTS);
	assign tail_rd = rd_vld_q ? rd_word_q[PW-1:0]    : PW'(SLOTS);

endmodule

### rtl/smq_seq.sv
// ----------------------------------------------------------------------------
// smq_seq: operation sequencer
// Steps one enqueue or dequeue through pointer lookup, link updates and
// result load; owns the free-list head, the fill counter and the result
// register.
// ----------------------------------------------------------------------------
module smq_seq #(
	parameter int SLOTS  = smq_pkg::SLOTS_DEF,
	parameter int QUEUES = smq_pkg::QUEUES_DEF,
	localparam int PW    = $clog2(SLOTS + 1),
	localparam int AW    = $clog2(SLOTS),
	localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [smq_pkg::QID_W-1:0]         queue_id,
	input  logic signed [smq_pkg::DATA_W-1:0] value,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [smq_pkg::STATUS_W-1:0]      status,
	output logic signed [smq_pkg::DATA_W-1:0] data_out,
	// queue table
	output smq_pkg::mem_ctl_t                 qt_ctl,
	output logic [QW-1:0]                     qt_rd_addr,
	output logic [QW-1:0]                     qt_wr_addr,
	output logic [PW-1:0]                     qt_head_wr,
	output logic [PW-1:0]                     qt_tail_wr,
	input  logic [PW-1:0]                     qt_head_rd,
	input  logic [PW-1:0]                     qt_tail_rd,
	// link store
	output smq_pkg::mem_ctl_t                 link_ctl,
	output logic [AW-1:0]                     link_rd_addr,
	output logic [AW-1:0]                     link_wr_addr,
	output logic [PW-1:0]                     link_wr_data,
	input  logic [PW-1:0]                     link_rd_data,
	// data store
	output smq_pkg::mem_ctl_t                 data_ctl,
	output logic [AW-1:0]                     data_rd_addr,
	output logic [AW-1:0]                     data_wr_addr,
	output logic [smq_pkg::DATA_W-1:0]        data_wr_data,
	input  logic [smq_pkg::DATA_W-1:0]        data_rd_data
);

	localparam int QMAP_N = 2 ** smq_pkg::QID_W;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	smq_pkg::state_t state_q, state_d;
	smq_pkg::op_t    op_q;
	logic [QW-1:0]   q_q;
	logic [smq_pkg::DATA_W-1:0] val_q;
	logic [PW-1:0]   free_head_q;
	logic [PW-1:0]   fill_q;
	logic [PW-1:0]   slot_q;
	logic            out_valid_q;
	smq_pkg::status_t status_q;
	logic [smq_pkg::DATA_W-1:0] data_q;

	logic [QW-1:0]   qmap [QMAP_N];
	logic            head_ok, tail_ok, fh_ok, touched, out_free;
	logic [PW-1:0]   next_free;
	logic            accept, load_out, take_slot, give_slot;
	smq_pkg::status_t res_status;
	logic [smq_pkg::DATA_W-1:0] res_data;

	// queue number wrap table
	for (genvar i = 0; i < QMAP_N; i++) begin : g_qmap
		assign qmap[i] = QW'(i % QUEUES);
	end

	// pointer checks
	assign head_ok   = qt_head_rd < NIL;
	assign tail_ok   = qt_tail_rd < NIL;
	assign fh_ok     = free_head_q < NIL;
	assign touched   = free_head_q < fill_q;
	assign out_free  = !out_valid_q || out_ready;
	// slots past the fill mark still chain in order
	assign next_free = touched ? link_rd_data : free_head_q + PW'(1);

	// fixed address routing
	assign qt_rd_addr   = qmap[queue_id];
	assign qt_wr_addr   = q_q;
	assign data_rd_addr = qt_head_rd[AW-1:0];
	assign data_wr_addr = free_head_q[AW-1:0];
	assign data_wr_data = val_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		accept       = 1'b0;
		load_out     = 1'b0;
		take_slot    = 1'b0;
		give_slot    = 1'b0;
		res_status   = smq_pkg::ST_OK;
		res_data     = '0;
		qt_ctl       = '0;
		qt_head_wr   = qt_head_rd;
		qt_tail_wr   = qt_tail_rd;
		link_ctl     = '0;
		link_rd_addr = free_head_q[AW-1:0];
		link_wr_addr = free_head_q[AW-1:0];
		link_wr_data = NIL;
		data_ctl     = '0;
		case (state_q)
			smq_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				qt_ctl.re   = 1'b1;
				link_ctl.re = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = smq_pkg::S_LOOKUP;
				end
			end
			smq_pkg::S_LOOKUP: begin
				if (op_q == smq_pkg::OP_ENQ) begin
					if (!fh_ok) begin
						res_status = smq_pkg::ST_FULL;
						if (out_free) begin
							load_out = 1'b1;
							state_d  = smq_pkg::S_IDLE;
						end
					end else if (head_ok && tail_ok) begin
						// append behind a live tail: link it in the link state
						take_slot = 1'b1;
						state_d   = smq_pkg::S_LINK;
					end else if (out_free) begin
						take_slot = 1'b1;
						load_out  = 1'b1;
						state_d   = smq_pkg::S_IDLE;
					end
					if (take_slot) begin
						link_ctl.we = 1'b1;
						data_ctl.we = 1'b1;
						qt_ctl.we   = 1'b1;
						qt_head_wr  = head_ok ? qt_head_rd : free_head_q;
						qt_tail_wr  = free_head_q;
					end
				end else begin
					if (!head_ok) begin
						res_status = smq_pkg::ST_EMPTY;
						if (out_free) begin
							load_out = 1'b1;
							state_d  = smq_pkg::S_IDLE;
						end
					end else begin
						link_ctl.re  = 1'b1;
						data_ctl.re  = 1'b1;
						link_rd_addr = qt_head_rd[AW-1:0];
						state_d      = smq_pkg::S_DEQ;
					end
				end
			end
			smq_pkg::S_LINK: begin
				link_wr_addr = qt_tail_rd[AW-1:0];
				link_wr_data = slot_q;
				if (out_free) begin
					link_ctl.we = 1'b1;
					load_out    = 1'b1;
					state_d     = smq_pkg::S_IDLE;
				end
			end
			smq_pkg::S_DEQ: begin
				res_data     = data_rd_data;
				link_wr_addr = qt_head_rd[AW-1:0];
				link_wr_data = free_head_q;
				qt_head_wr   = link_rd_data;
				if (out_free) begin
					link_ctl.we = 1'b1;
					qt_ctl.we   = 1'b1;
					give_slot   = 1'b1;
					load_out    = 1'b1;
					state_d     = smq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smq_pkg::S_IDLE;
			end
		endcase
	end

	// free list head and fill mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
		end else if (take_slot) begin
			free_head_q <= next_free;
			if (free_head_q == fill_q) begin
				fill_q <= fill_q + PW'(1);
			end
		end else if (give_slot) begin
			free_head_q <= qt_head_rd;
		end
	end

	// item capture and allocated slot
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= smq_pkg::op_t'(op);
			q_q   <= qmap[queue_id];
			val_q <= value;
		end
		if (take_slot) begin
			slot_q <= free_head_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_status;
			data_q   <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;

endmodule

### rtl/smq_check.sv
// ----------------------------------------------------------------------------
// smq_check: port-level checks for the shared-buffer multi-queue
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module smq_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              op,
	input logic [smq_pkg::QID_W-1:0]         queue_id,
	input logic signed [smq_pkg::DATA_W-1:0] value,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [smq_pkg::STATUS_W-1:0]      status,
	input logic signed [smq_pkg::DATA_W-1:0] data_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_out))
		else $error("result changed while stalled");

	// failed operations carry zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != smq_pkg::ST_OK |-> data_out == '0)
		else $error("nonzero data on full or empty result");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while working");

	// a new result only comes out of work on an item
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind shared_buffer_multi_queue smq_check u_smq_check (.*);

### verif/tb_shared_buffer_multi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue: self-checking bench for the shared multi-queue
// Drives enqueue and dequeue items over valid/ready, predicts status and data
// with a behavioral copy of the slot store, link table and free list, and
// checks every result in order under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue;

	localparam int SLOTS       = smq_pkg::SLOTS_DEF;
	localparam int QUEUES      = smq_pkg::QUEUES_DEF;
	localparam int QID_W       = smq_pkg::QID_W;
	localparam logic [6:0] NIL = 7'(SLOTS);
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		smq_pkg::status_t st;
		logic [31:0]      data;
	} result_t;

	// block ports
	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	logic                              op        = smq_pkg::OP_ENQ;
	logic [QID_W-1:0]                  queue_id  = '0;
	logic signed [smq_pkg::DATA_W-1:0] value     = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [smq_pkg::STATUS_W-1:0]      status;
	logic signed [smq_pkg::DATA_W-1:0] data_out;

	// behavioral copy of the queue store
	logic [31:0] slot_word [SLOTS];
	logic [6:0]  slot_next [SLOTS];
	logic [6:0]  q_first [QUEUES];
	logic [6:0]  q_last [QUEUES];
	logic [6:0]  free_first;

	result_t pending_results[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_cycles = 0;
	int stall_cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int n_enq_ok = 0;
	int n_full = 0;
	int n_deq_ok = 0;
	int n_empty = 0;

	shared_buffer_multi_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.queue_id  (queue_id),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_out  (data_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// store after reset: all queues empty, free list runs through every slot
	task automatic clear_queue_store();
		for (int i = 0; i < SLOTS; i++) begin
			slot_word[i] = '0;
			slot_next[i] = (i == SLOTS - 1) ? NIL : 7'(i + 1);
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_first[i] = NIL;
			q_last[i]  = NIL;
		end
		free_first = '0;
	endtask

	// apply one item to the behavioral store and work out its result
	task automatic predict_queue_op(input smq_pkg::op_t o, input logic [QID_W-1:0] q,
			input logic [31:0] v, output result_t r);
		logic [6:0] s;
		int qi;
		qi     = int'(q) % QUEUES;
		r.st   = smq_pkg::ST_OK;
		r.data = '0;
		if (o == smq_pkg::OP_ENQ) begin
			if (free_first >= NIL) begin
				r.st = smq_pkg::ST_FULL;
			end else begin
				s          = free_first;
				free_first = slot_next[s];
				// empty queue takes the slot as head, else link behind tail
				if (q_first[qi] >= NIL) begin
					q_first[qi] = s;
				end else if (q_last[qi] < NIL) begin
					slot_next[q_last[qi]] = s;
				end
				slot_next[s] = NIL;
				q_last[qi]   = s;
				slot_word[s] = v;
			end
		end else begin
			if (q_first[qi] >= NIL) begin
				r.st = smq_pkg::ST_EMPTY;
			end else begin
				s            = q_first[qi];
				q_first[qi]  = slot_next[s];
				slot_next[s] = free_first;
				free_first   = s;
				r.data       = slot_word[s];
			end
		end
	endtask

	// predict on input handshake, check on output handshake
	always @(posedge clk) begin
		result_t r;
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_queue_op(smq_pkg::op_t'(op), queue_id, value, r);
				pending_results.push_back(r);
				case (r.st)
					smq_pkg::ST_FULL:  n_full++;
					smq_pkg::ST_EMPTY: n_empty++;
					default: begin
						if (smq_pkg::op_t'(op) == smq_pkg::OP_ENQ) n_enq_ok++;
						else n_deq_ok++;
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected: status %0d data %h",
							$realtime, status, data_out);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st || data_out !== want.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: status exp %0d got %0d, data exp %h got %h",
								$realtime, want.st, status, want.data, data_out);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("tb_shared_buffer_multi_queue: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver: random idling plus an optional long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// offer one item; valid stays high on return so back-to-back items need no dip
	task automatic send_item(input smq_pkg::op_t o, input logic [QID_W-1:0] q,
			input logic [31:0] v);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		queue_id <= q;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering and let every expected result come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// extremes of the data word, both ops, empty queues and a queue emptied then reused
	task automatic test_directed();
		send_item(smq_pkg::OP_DEQ, 3'd0, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd7, 32'hffffffff);
		send_item(smq_pkg::OP_ENQ, 3'd0, 32'h80000000);
		send_item(smq_pkg::OP_ENQ, 3'd0, 32'h7fffffff);
		send_item(smq_pkg::OP_ENQ, 3'd7, 32'h00000000);
		send_item(smq_pkg::OP_ENQ, 3'd7, 32'hffffffff);
		send_item(smq_pkg::OP_ENQ, 3'd3, 32'h55555555);
		send_item(smq_pkg::OP_ENQ, 3'd3, 32'haaaaaaaa);
		send_item(smq_pkg::OP_DEQ, 3'd0, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd0, 32'h0);
		// queue 0 now empty with a stale tail
		send_item(smq_pkg::OP_DEQ, 3'd0, 32'h0);
		send_item(smq_pkg::OP_ENQ, 3'd0, 32'h00000123);
		send_item(smq_pkg::OP_DEQ, 3'd0, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd7, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd7, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd3, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd3, 32'h0);
		send_item(smq_pkg::OP_DEQ, 3'd3, 32'h0);
	endtask

	// hold off the receiver, fill every slot, overflow, then drain all queues
	task automatic test_store_full();
		wait_idle();
		hold_cycles = HOLD_CYCLES;
		for (int i = 0; i < SLOTS + 2; i++)
			send_item(smq_pkg::OP_ENQ, 3'(i % QUEUES), $urandom);
		for (int i = 0; i < SLOTS + QUEUES; i++)
			send_item(smq_pkg::OP_DEQ, 3'(i % QUEUES), $urandom);
	endtask

	// random traffic in bursts that push occupancy up, hold it, or drain it
	task automatic test_random_traffic(input int n_items);
		int burst_left;
		int enq_pct;
		logic [QID_W-1:0] hot_a;
		logic [QID_W-1:0] hot_b;
		logic [QID_W-1:0] q;
		logic [31:0] v;
		smq_pkg::op_t o;
		burst_left = 0;
		enq_pct    = 50;
		hot_a      = '0;
		hot_b      = '0;
		for (int i = 0; i < n_items; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(80, 20);
				case ($urandom_range(2))
					0:       enq_pct = 90;
					1:       enq_pct = 15;
					default: enq_pct = 50;
				endcase
				hot_a = QID_W'($urandom_range(QUEUES - 1));
				hot_b = QID_W'($urandom_range(QUEUES - 1));
			end
			burst_left--;
			o = ($urandom_range(99) < enq_pct) ? smq_pkg::OP_ENQ : smq_pkg::OP_DEQ;
			// half the items go to two busy queues
			if ($urandom_range(1)) q = $urandom_range(1) ? hot_a : hot_b;
			else q = QID_W'($urandom_range(QUEUES - 1));
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0:       v = 32'h80000000;
					1:       v = 32'h7fffffff;
					2:       v = 32'h00000000;
					default: v = 32'hffffffff;
				endcase
			end else begin
				v = $urandom;
			end
			send_item(o, q, v);
		end
	endtask

	// test sequence
	initial begin
		clear_queue_store();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(24, 53);
		test_directed();
		test_store_full();
		test_random_traffic(150);
		set_idling(53, 24);
		test_random_traffic(150);
		set_idling(0, 0);
		test_random_traffic(150);

		wait_idle();
		repeat (10) @(posedge clk);

		$display("ran %0d items: %0d enqueues stored, %0d refused full, %0d dequeues, %0d empty",
			items_sent, n_enq_ok, n_full, n_deq_ok, n_empty);
		$display("idling 24/53, 53/24 and none, one %0d-cycle output hold during store fill",
			HOLD_CYCLES);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_shared_buffer_multi_queue: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
			$display("tb_shared_buffer_multi_queue: FAIL");
		end
		$finish;
	end

endmodule
